@@ src/m3inv_pkg.sv @@
// ----------------------------------------------------------------------------
// m3inv_pkg
// shared widths, constants and types of the 3x3 matrix inverse core
// ----------------------------------------------------------------------------
package m3inv_pkg;

  localparam int ELEM_W        = 32;
  localparam int N_ELEM        = 9;
  localparam int COF_W         = 64;
  localparam int PRD_W         = 96;
  localparam int DET_W         = 97;
  localparam int QUO_W         = 33;
  localparam int FRAC_BITS_DEF = 16;
  localparam int DATA_W        = ELEM_W * N_ELEM;
  localparam int USER_W        = 2;

  localparam logic [ELEM_W-1:0] MAX_POS = 32'h7FFF_FFFF;
  localparam logic [ELEM_W-1:0] MIN_NEG = 32'h8000_0000;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [COF_W-1:0]  cof_t;
  typedef logic signed [PRD_W-1:0]  prd_t;
  typedef logic signed [DET_W-1:0]  det_t;
  typedef logic        [DET_W-1:0]  dmag_t;
  typedef logic        [QUO_W-1:0]  quo_t;

endpackage

@@ src/matrix3x3_inverse_core.sv @@
// ----------------------------------------------------------------------------
// matrix3x3_inverse_core
// throughput: one matrix per cycle, stalls only when the result is not taken
// depth dominated by the 33 one-bit restoring division stages per element
// reset clears the stage valid bits only, data registers are not reset
// ----------------------------------------------------------------------------
module matrix3x3_inverse_core
  import m3inv_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  logic [DATA_W-1:0] s_tdata_i,   // elem_r0c0 .. elem_r2c2, 32 bits each
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output logic [DATA_W-1:0] m_tdata_o,   // inv_r0c0 .. inv_r2c2, 32 bits each
  output logic [USER_W-1:0] m_tuser_o    // overflow (bit 1), singular (bit 0)
);

  localparam int NUM_W = COF_W + 2 * FRAC_BITS;
  localparam int CMP_W = DET_W + QUO_W + 1;
  localparam int NST   = 9 + QUO_W;

  logic           en;
  logic [NST-1:0] vld_q;

  elem_t a_q     [N_ELEM];
  cof_t  pa_q    [N_ELEM];
  cof_t  pb_q    [N_ELEM];
  elem_t r0_q    [3];
  elem_t r0b_q   [3];
  cof_t  cof_q   [N_ELEM];
  cof_t  cof3_q  [N_ELEM];
  cof_t  cof4_q  [N_ELEM];
  cof_t  cof5_q  [N_ELEM];
  logic signed [COF_W:0] pl_q [3];
  cof_t  ph_q    [3];
  prd_t  dp_q    [3];
  det_t  det_q;
  dmag_t dmag_q;
  logic  sing6_q;
  logic  [NUM_W-1:0] num_q [N_ELEM];
  logic  [N_ELEM-1:0] neg6_q;

  logic  [NUM_W-1:0]  rem_q [QUO_W+1][N_ELEM];
  quo_t               quo_q [QUO_W+1][N_ELEM];
  logic  [N_ELEM-1:0] pv_q  [QUO_W+1];
  logic  [N_ELEM-1:0] ng_q  [QUO_W+1];
  dmag_t              dm_q  [QUO_W+1];
  logic               sg_q  [QUO_W+1];

  logic  [NUM_W-1:0]  rem_d [QUO_W][N_ELEM];
  quo_t               quo_d [QUO_W][N_ELEM];

  elem_t inv_q [N_ELEM];
  logic  sing_q, ovf_q;

  cof_t  pa_d [N_ELEM];
  cof_t  pb_d [N_ELEM];
  cof_t  cof_d [N_ELEM];
  logic  [N_ELEM-1:0] pv_d;
  elem_t inv_d [N_ELEM];
  logic  ovf_d;

  assign en         = !vld_q[NST-1] || m_tready_i;
  assign s_tready_o = en;
  assign m_tvalid_o = vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], s_tvalid_i};
    end
  end

  // 2x2 minors as element products, cofactor sign applied by the order of the subtract
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        int r1, r2, k1, k2;
        r1 = (r == 0) ? 1 : 0;
        r2 = (r == 2) ? 1 : 2;
        k1 = (k == 0) ? 1 : 0;
        k2 = (k == 2) ? 1 : 2;
        pa_d[r*3+k] = cof_t'(a_q[r1*3+k1]) * cof_t'(a_q[r2*3+k2]);
        pb_d[r*3+k] = cof_t'(a_q[r1*3+k2]) * cof_t'(a_q[r2*3+k1]);
        cof_d[r*3+k] = ((r + k) % 2 == 1) ? (pb_q[r*3+k] - pa_q[r*3+k])
                                          : (pa_q[r*3+k] - pb_q[r*3+k]);
      end
    end
  end

  // one restoring division bit per stage
  always_comb begin
    for (int s = 0; s < QUO_W; s++) begin
      for (int e = 0; e < N_ELEM; e++) begin
        logic [CMP_W-1:0] dsh, rx;
        dsh = CMP_W'(dm_q[s]) << (QUO_W - 1 - s);
        rx  = CMP_W'(rem_q[s][e]);
        quo_d[s][e] = quo_q[s][e];
        rem_d[s][e] = rem_q[s][e];
        if (rx >= dsh) begin
          rem_d[s][e] = NUM_W'(rx - dsh);
          quo_d[s][e][QUO_W-1-s] = 1'b1;
        end
      end
    end
  end

  // precheck for quotients of 2^QUO_W and above
  always_comb begin
    for (int e = 0; e < N_ELEM; e++) begin
      pv_d[e] = CMP_W'(num_q[e]) >= (CMP_W'(dmag_q) << QUO_W);
    end
  end

  // rounding and saturation, singular results forced to zero
  always_comb begin
    ovf_d = 1'b0;
    for (int e = 0; e < N_ELEM; e++) begin
      logic [QUO_W:0]   qr;
      logic             rnd, sat;
      rnd = CMP_W'({rem_q[QUO_W][e], 1'b0}) >= CMP_W'(dm_q[QUO_W]);
      qr  = {1'b0, quo_q[QUO_W][e]} + (QUO_W+1)'(rnd);
      if (!ng_q[QUO_W][e]) begin
        sat      = pv_q[QUO_W][e] || (qr > (QUO_W+1)'(MAX_POS));
        inv_d[e] = sat ? elem_t'(MAX_POS) : elem_t'(qr[ELEM_W-1:0]);
      end else begin
        sat      = pv_q[QUO_W][e] || (qr > (QUO_W+1)'(MIN_NEG));
        inv_d[e] = sat ? elem_t'(MIN_NEG) : elem_t'(-qr[ELEM_W-1:0]);
      end
      if (sg_q[QUO_W]) begin
        inv_d[e] = '0;
        sat      = 1'b0;
      end
      ovf_d = ovf_d | sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int e = 0; e < N_ELEM; e++) begin
        a_q[e]    <= elem_t'(s_tdata_i[e*ELEM_W +: ELEM_W]);
        pa_q[e]   <= pa_d[e];
        pb_q[e]   <= pb_d[e];
        cof_q[e]  <= cof_d[e];
        // transpose into the adjugate
        cof3_q[e] <= cof_q[(e % 3) * 3 + e / 3];
        cof4_q[e] <= cof3_q[e];
        cof5_q[e] <= cof4_q[e];
        num_q[e]  <= NUM_W'(cof5_q[e][COF_W-1] ? -cof5_q[e] : cof5_q[e]) << (2 * FRAC_BITS);
        neg6_q[e] <= cof5_q[e][COF_W-1] ^ det_q[DET_W-1];
        rem_q[0][e] <= num_q[e];
        quo_q[0][e] <= '0;
        inv_q[e]  <= inv_d[e];
      end
      for (int k = 0; k < 3; k++) begin
        r0_q[k]  <= a_q[k];
        r0b_q[k] <= r0_q[k];
        pl_q[k]  <= (COF_W+1)'(r0b_q[k]) * $signed({1'b0, cof_q[k][ELEM_W-1:0]});
        ph_q[k]  <= cof_t'(r0b_q[k]) * cof_t'($signed(cof_q[k][COF_W-1:ELEM_W]));
        dp_q[k]  <= (prd_t'(ph_q[k]) <<< ELEM_W) + prd_t'(pl_q[k]);
      end
      det_q   <= det_t'(dp_q[0]) + det_t'(dp_q[1]) + det_t'(dp_q[2]);
      dmag_q  <= det_q[DET_W-1] ? dmag_t'(-det_q) : dmag_t'(det_q);
      sing6_q <= (det_q == '0);
      pv_q[0] <= pv_d;
      ng_q[0] <= neg6_q;
      dm_q[0] <= dmag_q;
      sg_q[0] <= sing6_q;
      for (int s = 0; s < QUO_W; s++) begin
        rem_q[s+1] <= rem_d[s];
        quo_q[s+1] <= quo_d[s];
        pv_q[s+1]  <= pv_q[s];
        ng_q[s+1]  <= ng_q[s];
        dm_q[s+1]  <= dm_q[s];
        sg_q[s+1]  <= sg_q[s];
      end
      sing_q <= sg_q[QUO_W];
      ovf_q  <= ovf_d;
    end
  end

  always_comb begin
    for (int e = 0; e < N_ELEM; e++) begin
      m_tdata_o[e*ELEM_W +: ELEM_W] = inv_q[e];
    end
  end

  assign m_tuser_o = {ovf_q, sing_q};

  a_sing_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && sing_q |-> (m_tdata_o == '0) && !ovf_q)
    else $error("singular result with nonzero data or overflow");

  a_ovf_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && ovf_q |->
      (inv_q[0] == elem_t'(MAX_POS)) || (inv_q[0] == elem_t'(MIN_NEG)) ||
      (inv_q[1] == elem_t'(MAX_POS)) || (inv_q[1] == elem_t'(MIN_NEG)) ||
      (inv_q[2] == elem_t'(MAX_POS)) || (inv_q[2] == elem_t'(MIN_NEG)) ||
      (inv_q[3] == elem_t'(MAX_POS)) || (inv_q[3] == elem_t'(MIN_NEG)) ||
      (inv_q[4] == elem_t'(MAX_POS)) || (inv_q[4] == elem_t'(MIN_NEG)) ||
      (inv_q[5] == elem_t'(MAX_POS)) || (inv_q[5] == elem_t'(MIN_NEG)) ||
      (inv_q[6] == elem_t'(MAX_POS)) || (inv_q[6] == elem_t'(MIN_NEG)) ||
      (inv_q[7] == elem_t'(MAX_POS)) || (inv_q[7] == elem_t'(MIN_NEG)) ||
      (inv_q[8] == elem_t'(MAX_POS)) || (inv_q[8] == elem_t'(MIN_NEG)))
    else $error("overflow flagged without a saturated element");

  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline valid bits moved during a stall");

endmodule
